// ===== src/psd_pkg.sv =====
// Package for the point-to-segment distance unit: payload structs, widths
// and constants. No dependencies.
package psd_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int T_FRAC_BITS_DEF = 16;
  localparam int DIST_WIDTH      = 17;
  localparam logic [DIST_WIDTH-1:0] DIST_MAX = {DIST_WIDTH{1'b1}};

  typedef struct packed {
    logic signed [COORD_WIDTH_DEF-1:0] seg_start_x;
    logic signed [COORD_WIDTH_DEF-1:0] seg_start_y;
    logic signed [COORD_WIDTH_DEF-1:0] seg_end_x;
    logic signed [COORD_WIDTH_DEF-1:0] seg_end_y;
    logic signed [COORD_WIDTH_DEF-1:0] query_x;
    logic signed [COORD_WIDTH_DEF-1:0] query_y;
  } psd_in_t;

  typedef struct packed {
    logic [DIST_WIDTH-1:0] distance;
    logic                  degenerate;
  } psd_out_t;

endpackage

// ===== src/psd_div.sv =====
// Pipelined restoring divider: one quotient bit per stage.
// Depends on nothing; stall is a common enable for all stages.
module psd_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 32,
  parameter int Q_W   = 16,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic [Q_W-1:0]    quo,
  output logic [SIDE_W-1:0] side_out
);

  // remainder stays below den, so DEN_W+1 bits suffice
  logic [DEN_W:0]    rem_r  [Q_W+1];
  logic [NUM_W-1:0]  num_r  [Q_W+1];
  logic [DEN_W-1:0]  den_r  [Q_W+1];
  logic [Q_W-1:0]    quo_r  [Q_W+1];
  logic [SIDE_W-1:0] side_r [Q_W+1];

  // upper DEN_W numerator bits seed the remainder; the low Q_W bits are
  // brought down one per stage
  always_comb begin
    rem_r[0]  = {1'b0, num[Q_W +: DEN_W]};
    num_r[0]  = num;
    den_r[0]  = den;
    quo_r[0]  = '0;
    side_r[0] = side_in;
  end

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic [DEN_W+1:0] trial;
    logic             bit_in;
    assign bit_in = num_r[i][Q_W-1-i];
    assign trial  = {rem_r[i], bit_in} - {2'b00, den_r[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!trial[DEN_W+1]) begin
          rem_r[i+1] <= trial[DEN_W:0];
        end else begin
          rem_r[i+1] <= {rem_r[i][DEN_W-1:0], bit_in};
        end
        quo_r[i+1]  <= {quo_r[i][Q_W-2:0], ~trial[DEN_W+1]};
        num_r[i+1]  <= num_r[i];
        den_r[i+1]  <= den_r[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign quo      = quo_r[Q_W];
  assign side_out = side_r[Q_W];

endmodule

// ===== src/psd_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on nothing; stall is a common enable for all stages.
module psd_sqrt #(
  parameter int V_W    = 64,
  parameter int SIDE_W = 8
) (
  input  logic               clk,
  input  logic               en,
  input  logic [V_W-1:0]     val,
  input  logic [SIDE_W-1:0]  side_in,
  output logic [V_W/2-1:0]   root,
  output logic [SIDE_W-1:0]  side_out
);

  localparam int R_W = V_W / 2;

  logic [V_W-1:0]    v_r    [R_W+1];
  logic [R_W+1:0]    rem_r  [R_W+1];
  logic [R_W-1:0]    rt_r   [R_W+1];
  logic [SIDE_W-1:0] side_r [R_W+1];

  always_comb begin
    v_r[0]    = val;
    rem_r[0]  = '0;
    rt_r[0]   = '0;
    side_r[0] = side_in;
  end

  // digit recurrence: bring down two bits, try 4*root+1
  for (genvar i = 0; i < R_W; i++) begin : g_stage
    logic [R_W+3:0] cur;
    logic [R_W+3:0] trial;
    assign cur   = {rem_r[i], v_r[i][V_W-1-2*i -: 2]};
    assign trial = cur - {2'b00, rt_r[i], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!trial[R_W+3]) begin
          rem_r[i+1] <= trial[R_W+1:0];
        end else begin
          rem_r[i+1] <= cur[R_W+1:0];
        end
        rt_r[i+1]   <= {rt_r[i][R_W-2:0], ~trial[R_W+3]};
        v_r[i+1]    <= v_r[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign root     = rt_r[R_W];
  assign side_out = side_r[R_W];

endmodule

// ===== src/point_segment_distance_unit.sv =====
// Top level of the point-to-segment distance unit.
// Depends on psd_pkg, psd_div and psd_sqrt.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one segment (start,
//   end) and one query point, signed Q11.4. Output channel
//   out_valid/out_ready/out_data returns the floor distance from the point
//   to the nearest segment point (unsigned Q.4, saturated) and a flag for a
//   zero-length segment.
//   Throughput: one request per cycle while the receiver does not stall.
//   The pipeline depth is set mostly by the bit-per-stage divider for the
//   projection parameter and the bit-per-stage square root.
//   The whole pipeline advances together; when the receiver stalls with a
//   valid result in the output stage, every stage holds and in_ready drops.
//   Empty bubbles in the pipeline are not squeezed out while stalled.
//   Reset (rst_n low, synchronous) clears all valid bits; data registers
//   are not reset.
module point_segment_distance_unit #(
  parameter int T_FRAC_BITS = psd_pkg::T_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  psd_pkg::psd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output psd_pkg::psd_out_t out_data
);
  import psd_pkg::*;

  localparam int CW   = COORD_WIDTH_DEF;
  localparam int DW   = CW + 1;          // differences
  localparam int SQW  = 2 * DW + 1;      // sums of squares / dot
  localparam int TW   = T_FRAC_BITS + 1; // t including 1.0
  localparam int NUMW = SQW + T_FRAC_BITS;
  localparam int DIVL = T_FRAC_BITS;
  localparam int PW   = DW + TW + 1;     // scaled offset product
  localparam int EW   = CW + 3;          // error vector component
  localparam int RV_W = 2 * EW + 2;      // even root input width
  localparam int RW   = RV_W / 2;
  localparam int NST  = 7 + DIVL + RW;   // total stages incl. output

  // Global advance: a stage shifts unless the last one holds a stalled result
  logic [NST-1:0] vld_r;
  logic           adv;
  assign adv       = !vld_r[NST-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // Stage 1: differences
  logic signed [DW-1:0] dx_r, dy_r, px_r, py_r;
  logic signed [CW-1:0] sx_r, sy_r, qx_r, qy_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r <= DW'(in_data.seg_end_x) - DW'(in_data.seg_start_x);
      dy_r <= DW'(in_data.seg_end_y) - DW'(in_data.seg_start_y);
      px_r <= DW'(in_data.query_x) - DW'(in_data.seg_start_x);
      py_r <= DW'(in_data.query_y) - DW'(in_data.seg_start_y);
      sx_r <= in_data.seg_start_x;
      sy_r <= in_data.seg_start_y;
      qx_r <= in_data.query_x;
      qy_r <= in_data.query_y;
    end
  end

  // Stage 2: products
  logic signed [2*DW-1:0] m_dxdx_r, m_dydy_r, m_pxdx_r, m_pydy_r, m_pxpx_r, m_pypy_r;
  logic signed [DW-1:0]   dx2_r, dy2_r;
  logic signed [CW-1:0]   sx2_r, sy2_r, qx2_r, qy2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      m_dxdx_r <= dx_r * dx_r;
      m_dydy_r <= dy_r * dy_r;
      m_pxdx_r <= px_r * dx_r;
      m_pydy_r <= py_r * dy_r;
      m_pxpx_r <= px_r * px_r;
      m_pypy_r <= py_r * py_r;
      dx2_r <= dx_r; dy2_r <= dy_r;
      sx2_r <= sx_r; sy2_r <= sy_r; qx2_r <= qx_r; qy2_r <= qy_r;
    end
  end

  // Stage 3: sums, clamp decision
  logic [SQW-1:0]        len2_c;
  logic signed [SQW-1:0] dot_c;
  assign len2_c = SQW'($unsigned(m_dxdx_r)) + SQW'($unsigned(m_dydy_r));
  assign dot_c  = SQW'(m_pxdx_r) + SQW'(m_pydy_r);

  typedef struct packed {
    logic                 degen;
    logic                 t_zero;
    logic                 t_one;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] qx;
    logic signed [CW-1:0] qy;
  } side_t;

  side_t          side3_r;
  logic [SQW-1:0] num3_r, len3_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      side3_r.degen  <= (len2_c == '0);
      side3_r.t_zero <= (dot_c <= 0) || (len2_c == '0);
      side3_r.t_one  <= (dot_c > 0) && ($unsigned(dot_c) >= len2_c);
      side3_r.dx <= dx2_r; side3_r.dy <= dy2_r;
      side3_r.sx <= sx2_r; side3_r.sy <= sy2_r;
      side3_r.qx <= qx2_r; side3_r.qy <= qy2_r;
      num3_r <= $unsigned(dot_c);
      len3_r <= (len2_c == '0) ? SQW'(1) : len2_c;
    end
  end

  // Divider: t = (dot << F) / len2, valid only for 0 < dot < len2
  // so quotient fits T_FRAC_BITS bits.
  logic [DIVL-1:0] tq;
  side_t           side4;
  psd_div #(.NUM_W(NUMW), .DEN_W(SQW), .Q_W(DIVL), .SIDE_W($bits(side_t))) u_div (
    .clk(clk), .en(adv),
    .num({num3_r, {T_FRAC_BITS{1'b0}}}),
    .den(len3_r),
    .side_in(side3_r),
    .quo(tq),
    .side_out(side4)
  );
  // dot < len2, so dot itself seeds the remainder and only the
  // T_FRAC_BITS appended zeros are divided through.

  // Stage 4: select t, form |d|*t
  logic [TW-1:0] t_c;
  always_comb begin
    if (side4.t_zero) begin
      t_c = '0;
    end else if (side4.t_one) begin
      t_c = TW'(1) << T_FRAC_BITS;
    end else begin
      t_c = TW'(tq);
    end
  end

  logic [DW-1:0]  mx_c, my_c;
  assign mx_c = side4.dx[DW-1] ? DW'(-side4.dx) : DW'(side4.dx);
  assign my_c = side4.dy[DW-1] ? DW'(-side4.dy) : DW'(side4.dy);

  logic [PW-1:0] prx_r, pry_r;
  side_t         side5_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      prx_r   <= PW'(mx_c) * PW'(t_c);
      pry_r   <= PW'(my_c) * PW'(t_c);
      side5_r <= side4;
    end
  end

  // Stage 5: round, project, error vector
  logic [PW-1:0]         rx_c, ry_c;
  logic signed [EW-1:0]  ox_c, oy_c, ex_c, ey_c;
  assign rx_c = (prx_r + (PW'(1) << (T_FRAC_BITS - 1))) >> T_FRAC_BITS;
  assign ry_c = (pry_r + (PW'(1) << (T_FRAC_BITS - 1))) >> T_FRAC_BITS;
  assign ox_c = side5_r.dx[DW-1] ? -EW'(rx_c) : EW'(rx_c);
  assign oy_c = side5_r.dy[DW-1] ? -EW'(ry_c) : EW'(ry_c);
  assign ex_c = EW'(side5_r.qx) - EW'(side5_r.sx) - ox_c;
  assign ey_c = EW'(side5_r.qy) - EW'(side5_r.sy) - oy_c;

  logic signed [EW-1:0] ex_r, ey_r;
  logic                 deg6_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      ex_r   <= ex_c;
      ey_r   <= ey_c;
      deg6_r <= side5_r.degen;
    end
  end

  // Stage 6: squared distance
  logic [2*EW-1:0] sqx_r, sqy_r;
  logic            deg7_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sqx_r  <= $unsigned((2*EW)'(ex_r) * (2*EW)'(ex_r));
      sqy_r  <= $unsigned((2*EW)'(ey_r) * (2*EW)'(ey_r));
      deg7_r <= deg6_r;
    end
  end

  // Square root
  logic [RW-1:0] root;
  logic          deg_o;
  psd_sqrt #(.V_W(RV_W), .SIDE_W(1)) u_sqrt (
    .clk(clk), .en(adv),
    .val(RV_W'(sqx_r) + RV_W'(sqy_r)),
    .side_in(deg7_r),
    .root(root),
    .side_out(deg_o)
  );

  // Output register with saturation
  psd_out_t out_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.distance   <= (root > RW'(DIST_MAX)) ? DIST_MAX : DIST_WIDTH'(root);
      out_r.degenerate <= deg_o;
    end
  end
  assign out_data = out_r;

endmodule
